### rtl/pde_pkg.sv
// Package for the packed decimal encoder: beat types, sizing constants and
// the shift-and-add-3 step used by the binary to BCD pipeline. No dependencies.
package pde_pkg;

    localparam int MAG_W          = 60;
    localparam int CNT_W          = 5;
    localparam int BCD_DIGITS     = 19;
    localparam int BCD_W          = 4 * BCD_DIGITS;
    localparam int DABBLE_STEPS   = 4;
    localparam int DABBLE_STAGES  = (MAG_W + DABBLE_STEPS - 1) / DABBLE_STEPS;
    localparam int BIN_W          = DABBLE_STAGES * DABBLE_STEPS;

    localparam int DEF_PACK_BYTES = 10;
    localparam int DEF_MAX_DIGITS = 18;

    localparam logic [3:0] SIGN_POS = 4'hC;
    localparam logic [3:0] SIGN_NEG = 4'hD;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             negative;
        logic [CNT_W-1:0] digit_count;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } out_beat_t;

    // One double-dabble step: add 3 to every digit of 5 or more, shift in a bit.
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic bin_bit);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (adj[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bin_bit};
    endfunction

endpackage

### rtl/packed_decimal_encoder.sv
// Packed decimal encoder top level: BCD conversion pipeline, packing stage
// and byte serializer. Depends on pde_pkg.

// Each input beat carries a scaled magnitude, a sign flag and a digit count;
// the block emits PACK_BYTES output beats, one byte of the packed decimal field
// each, most significant first, with last_byte high on the final one. The low
// digit_count decimal digits of the magnitude are kept (counts above MAX_DIGITS
// act as MAX_DIGITS); an odd count starts with a digit in the high nibble of
// the first byte, an even count with a zero nibble, the sign nibble (0xC
// positive, 0xD negative) follows the last digit and all later bytes are zero.
// Sustained throughput is set by the byte-wide output channel: each item takes
// PACK_BYTES output beats (10 by default). The input register takes the beat at
// its accept edge, then a 15-stage shift-and-add-3 binary to BCD pipeline
// (four bit steps per stage), one packing stage and the output register of the
// serializer follow. The pipeline keeps taking items while the serializer
// drains earlier ones and stalls as a whole, losing nothing, when a packed
// field is waiting and the serializer is still busy.
module packed_decimal_encoder #(
    parameter int PACK_BYTES = pde_pkg::DEF_PACK_BYTES,
    parameter int MAX_DIGITS = pde_pkg::DEF_MAX_DIGITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pde_pkg::in_beat_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pde_pkg::out_beat_t out_data
);

    localparam int NIBS  = 2 * PACK_BYTES;
    localparam int IDX_W = $clog2(PACK_BYTES);
    localparam int DS    = pde_pkg::DABBLE_STAGES;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACK_BYTES - 1);
    localparam logic [pde_pkg::CNT_W-1:0] MAX_CNT = pde_pkg::CNT_W'(MAX_DIGITS);

    // Conversion pipeline: stage 0 is the input register, stages 1..DS dabble.
    logic                      vld_reg [0:DS];
    logic [pde_pkg::BIN_W-1:0] bin_reg [0:DS];
    logic [pde_pkg::BCD_W-1:0] bcd_reg [0:DS];
    logic [pde_pkg::CNT_W-1:0] cnt_reg [0:DS];
    logic                      neg_reg [0:DS];

    logic [pde_pkg::BIN_W-1:0] bin_next [1:DS];
    logic [pde_pkg::BCD_W-1:0] bcd_next [1:DS];

    // Packing stage.
    logic       pack_vld_reg;
    logic [7:0] pack_reg  [PACK_BYTES];
    logic [7:0] pack_next [PACK_BYTES];

    // Serializer.
    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       field_reg [PACK_BYTES];

    logic advance;
    logic ser_load;
    logic out_take;
    logic [pde_pkg::CNT_W-1:0] cnt_clamped;

    assign out_take = out_valid && out_ready;
    assign ser_load = pack_vld_reg && (!busy_reg || (out_take && idx_reg == LAST_IDX));
    // Advance the whole pipeline unless the packed field has nowhere to go.
    assign advance  = !pack_vld_reg || ser_load;
    assign in_ready = advance;

    assign cnt_clamped = (in_data.digit_count > MAX_CNT) ? MAX_CNT : in_data.digit_count;

    // Four shift-and-add-3 steps per stage; stages are independent.
    always_comb
    begin
        logic [pde_pkg::BIN_W-1:0] b;
        logic [pde_pkg::BCD_W-1:0] c;
        for (int s = 1; s <= DS; s++) begin
            b = bin_reg[s-1];
            c = bcd_reg[s-1];
            for (int t = 0; t < pde_pkg::DABBLE_STEPS; t++) begin
                c = pde_pkg::dabble_step(c, b[pde_pkg::BIN_W-1]);
                b = {b[pde_pkg::BIN_W-2:0], 1'b0};
            end
            bin_next[s] = b;
            bcd_next[s] = c;
        end
    end

    // Lay out nibbles: a leading zero for an even count, digits, then sign at an odd position, zeros after.
    always_comb
    begin
        logic [3:0] nib [NIBS];
        int         sign_idx;
        int         k;
        sign_idx = 2 * int'(cnt_reg[DS] >> 1) + 1;
        for (int p = 0; p < NIBS; p++) begin
            k = sign_idx - 1 - p;
            if (p == sign_idx) begin
                nib[p] = neg_reg[DS] ? pde_pkg::SIGN_NEG : pde_pkg::SIGN_POS;
            end
            else if (p < sign_idx && k < int'(cnt_reg[DS])) begin
                nib[p] = bcd_reg[DS][4*k +: 4];
            end
            else begin
                nib[p] = 4'h0;
            end
        end
        for (int b = 0; b < PACK_BYTES; b++) begin
            pack_next[b] = {nib[2*b], nib[2*b+1]};
        end
    end

    // Control: valid bits of the pipeline and serializer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s <= DS; s++) begin
                vld_reg[s] <= 1'b0;
            end
            pack_vld_reg <= 1'b0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
        end
        else begin
            if (advance) begin
                vld_reg[0] <= in_valid;
                for (int s = 1; s <= DS; s++) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
                pack_vld_reg <= vld_reg[DS];
            end
            if (ser_load) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (out_take) begin
                if (idx_reg == LAST_IDX) begin
                    busy_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (advance) begin
            bin_reg[0] <= pde_pkg::BIN_W'(in_data.magnitude);
            bcd_reg[0] <= '0;
            cnt_reg[0] <= cnt_clamped;
            neg_reg[0] <= in_data.negative;
            for (int s = 1; s <= DS; s++) begin
                bin_reg[s] <= bin_next[s];
                bcd_reg[s] <= bcd_next[s];
                cnt_reg[s] <= cnt_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
            for (int b = 0; b < PACK_BYTES; b++) begin
                pack_reg[b] <= pack_next[b];
            end
        end
        if (ser_load) begin
            for (int b = 0; b < PACK_BYTES; b++) begin
                field_reg[b] <= pack_reg[b];
            end
        end
    end

    assign out_valid             = busy_reg;
    assign out_data.packed_byte  = field_reg[idx_reg];
    assign out_data.last_byte    = (idx_reg == LAST_IDX);

endmodule

### test/packed_decimal_encoder_tb.sv
// Self-checking testbench for packed_decimal_encoder: a directed table, then
// random beats under several idle and stall mixes. Depends on pde_pkg and the RTL.
`timescale 1ns / 1ps

module packed_decimal_encoder_tb;

    localparam int PACK_BYTES = pde_pkg::DEF_PACK_BYTES;
    localparam int MAX_DIGITS = pde_pkg::DEF_MAX_DIGITS;
    localparam int FIELD_W    = 8 * PACK_BYTES;
    localparam int RANDOM_PER_PHASE = 32;
    localparam int DRAIN_CYCLES     = 40;

    // One row of the directed table. has_field marks rows whose packed field
    // is written out by hand; the rest go through the predictor.
    typedef struct {
        logic [pde_pkg::MAG_W-1:0] magnitude;
        logic                      negative;
        logic [pde_pkg::CNT_W-1:0] count;
        bit                        has_field;
        logic [FIELD_W-1:0]        field;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 20;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // zero count: only a zero nibble and the sign
        '{60'd0, 1'b0, 5'd0, 1'b1, 80'h0C00_0000_0000_0000_0000},
        '{60'd0, 1'b1, 5'd0, 1'b1, 80'h0D00_0000_0000_0000_0000},
        // odd count puts the first digit in the high nibble
        '{60'd7, 1'b1, 5'd1, 1'b1, 80'h7D00_0000_0000_0000_0000},
        // even count leads with a zero nibble; the hundreds digit is dropped
        '{60'd123, 1'b0, 5'd2, 1'b1, 80'h023C_0000_0000_0000_0000},
        // negative zero keeps the negative sign
        '{60'd0, 1'b1, 5'd5, 1'b1, 80'h0000_0D00_0000_0000_0000},
        '{60'd12345678901234567, 1'b0, 5'd17, 1'b1, 80'h1234_5678_9012_3456_7C00},
        // widest legal count, all nines
        '{60'd999999999999999999, 1'b0, 5'd18, 1'b1, 80'h0999_9999_9999_9999_999C},
        // all-ones magnitude above range, count clamped from 31 to 18
        '{60'hFFF_FFFF_FFFF_FFFF, 1'b1, 5'd31, 1'b1, 80'h0152_9215_0460_6846_975D},
        '{60'd999999999999999999, 1'b1, 5'd19, 1'b0, '0},
        '{60'hFFF_FFFF_FFFF_FFFF, 1'b0, 5'd18, 1'b0, '0},
        '{60'hAAA_AAAA_AAAA_AAAA, 1'b1, 5'd24, 1'b0, '0},
        '{60'h555_5555_5555_5555, 1'b0, 5'd13, 1'b0, '0},
        '{60'd9, 1'b0, 5'd1, 1'b0, '0},
        '{60'd10, 1'b0, 5'd1, 1'b0, '0},
        '{60'd98765, 1'b1, 5'd4, 1'b0, '0},
        '{60'd1000000000, 1'b0, 5'd10, 1'b0, '0},
        '{60'd314159, 1'b1, 5'd6, 1'b0, '0},
        '{60'd1, 1'b0, 5'd16, 1'b0, '0},
        '{60'h800_0000_0000_0000, 1'b1, 5'd30, 1'b0, '0},
        '{60'd42, 1'b0, 5'd3, 1'b0, '0}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    pde_pkg::in_beat_t   in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    pde_pkg::out_beat_t  out_data;

    pde_pkg::out_beat_t  expected_bytes [$];
    int                  failures = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;

    packed_decimal_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Work out the whole packed field for one input beat. Nibble 0 is the
    // high nibble of the first byte sent; the sign sits right after the
    // last kept digit and everything past it stays zero.
    function automatic logic [FIELD_W-1:0] pack_decimal(input pde_pkg::in_beat_t beat);
        logic [3:0]         nib [2*PACK_BYTES];
        logic [63:0]        rest;
        int                 digits;
        int                 sign_at;
        logic [FIELD_W-1:0] field;
        rest    = 64'(beat.magnitude);
        digits  = (beat.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(beat.digit_count);
        sign_at = 2 * (digits / 2 + 1) - 1;
        for (int i = 0; i < 2*PACK_BYTES; i++)
            nib[i] = 4'h0;
        for (int k = 0; k < digits; k++)
        begin
            nib[sign_at - 1 - k] = 4'(rest % 10);
            rest = rest / 10;
        end
        nib[sign_at] = beat.negative ? pde_pkg::SIGN_NEG : pde_pkg::SIGN_POS;
        for (int i = 0; i < 2*PACK_BYTES; i++)
            field[FIELD_W - 1 - 4*i -: 4] = nib[i];
        return field;
    endfunction

    // Split a field into the byte beats the block should send, first byte first.
    task automatic queue_field(input logic [FIELD_W-1:0] field);
        pde_pkg::out_beat_t beat;
        for (int b = 0; b < PACK_BYTES; b++)
        begin
            beat.packed_byte = field[FIELD_W - 1 - 8*b -: 8];
            beat.last_byte   = (b == PACK_BYTES - 1);
            expected_bytes.push_back(beat);
        end
    endtask

    // Offer one beat. Entered and left at a falling edge; valid stays high
    // into the next beat unless an idle gap is drawn, so it is never
    // dropped and raised in the same step.
    task automatic send_number(input pde_pkg::in_beat_t beat, input bit has_field,
                               input logic [FIELD_W-1:0] field);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = beat;
        // hold the beat until the block takes it
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (has_field)
            queue_field(field);
        else
            queue_field(pack_decimal(beat));
        @(negedge clk);
    endtask

    // Hold the sender off until every queued byte has come out.
    task automatic drain_bytes();
        in_valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: draw a fresh ready at every falling edge.
    always @(negedge clk)
        out_ready = ($urandom_range(99) >= recv_stall_pct);

    // Checker: compare each accepted byte beat with the oldest expectation.
    always @(posedge clk)
    begin
        pde_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected beat: packed_byte=%h last_byte=%b",
                       out_data.packed_byte, out_data.last_byte);
                failures++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_data.packed_byte !== want.packed_byte)
                begin
                    $error("packed_byte: expected %h, got %h",
                           want.packed_byte, out_data.packed_byte);
                    failures++;
                end
                if (out_data.last_byte !== want.last_byte)
                begin
                    $error("last_byte: expected %b, got %b",
                           want.last_byte, out_data.last_byte);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        pde_pkg::in_beat_t beat;
        int                shape;
        logic [63:0]       scale;
        int                idle_mix [4];
        int                stall_mix [4];
        idle_mix  = '{0, 80, 0, 11};
        stall_mix = '{0, 0, 80, 11};

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table, no idling
        foreach (directed_rows[r])
        begin
            beat.magnitude   = directed_rows[r].magnitude;
            beat.negative    = directed_rows[r].negative;
            beat.digit_count = directed_rows[r].count;
            send_number(beat, directed_rows[r].has_field, directed_rows[r].field);
        end
        drain_bytes();

        // random beats, one idle/stall mix per phase; let the block go empty
        // between phases so gaps land on a quiet block as well as a busy one
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_mix[ph];
            recv_stall_pct = stall_mix[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                shape            = $urandom_range(9);
                beat.negative    = 1'($urandom_range(1));
                beat.digit_count = pde_pkg::CNT_W'($urandom_range(1, MAX_DIGITS));
                case (shape)
                    0:
                    begin
                        // anything the fields allow
                        beat.digit_count = pde_pkg::CNT_W'($urandom_range(31));
                        beat.magnitude   = pde_pkg::MAG_W'({$urandom(), $urandom()});
                    end
                    1:
                    begin
                        // count past the clamp, any magnitude the field allows
                        beat.digit_count = pde_pkg::CNT_W'($urandom_range(MAX_DIGITS + 1, 31));
                        beat.magnitude   = pde_pkg::MAG_W'({$urandom(), $urandom()});
                    end
                    2:
                        beat.magnitude = pde_pkg::MAG_W'($urandom_range(99));
                    default:
                    begin
                        // well-formed: magnitude fits the count
                        scale = 64'd1;
                        repeat (beat.digit_count)
                            scale = scale * 10;
                        beat.magnitude = pde_pkg::MAG_W'({$urandom(), $urandom()} % scale);
                    end
                endcase
                send_number(beat, 1'b0, '0);
            end
            drain_bytes();
        end

        // nothing is expected now; give stray beats time to show up
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(4_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
